// ===== design/tmr_pkg.sv =====
// shared types, codes and constants of the software timer table
package tmr_pkg;

    // table dimensions
    localparam int TIMER_SLOTS = 16;
    localparam int TASK_COUNT  = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int TICK_W      = 64;
    localparam int PERIOD_W    = 32;
    localparam int OWNER_W     = 5;

    // owner code of a slot with no task
    localparam logic [OWNER_W-1:0] OWNER_NONE = OWNER_W'(TASK_COUNT % 32);
    localparam logic [SLOT_W-1:0]  LAST_IDX   = SLOT_W'(TIMER_SLOTS - 1);

    // operation codes of the kind field
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_ADD    = 3'd1,
        OP_START  = 3'd2,
        OP_STOP   = 3'd3,
        OP_SETVAL = 3'd4,
        OP_CHECK  = 3'd5
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_FULL    = 3'd1,
        ST_EXPIRED = 3'd2,
        ST_NONE    = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_EMIT
    } tmr_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    latch;
        logic    idx_inc;
        logic    idx_zero;
        logic    mask_wr;
        logic    tick;
        logic    add_wr;
        logic    start_wr;
        logic    stop_wr;
        logic    period_wr;
        logic    expire_wr;
        logic    out_load;
        status_t out_status;
        logic    out_use_idx;
        logic    out_use_owner;
        logic    out_last;
    } tmr_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [2:0] kind;
        logic       idx_last;
        logic       slot_free;
        logic       slot_ok;
        logic       slot_running;
        logic       mask_zero;
        logic       mask_bit;
        logic       mask_last;
    } tmr_stat_t;

endpackage

// ===== design/tmr_req_if.sv =====
// request channel carrying one operation word
interface tmr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [31:0] period_ms;
    logic        periodic;
    logic [4:0]  requester_task;

    modport source (output valid, kind, slot, period_ms, periodic, requester_task,
                    input ready);
    modport sink   (input valid, kind, slot, period_ms, periodic, requester_task,
                    output ready);
    modport monitor (input valid, ready, kind, slot, period_ms, periodic,
                     requester_task);
endinterface

// ===== design/tmr_rsp_if.sv =====
// response channel carrying one result word
interface tmr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] slot_out;
    logic [4:0] owner_out;
    logic       last;

    modport source (output valid, status, slot_out, owner_out, last, input ready);
    modport sink   (input valid, status, slot_out, owner_out, last, output ready);
    modport monitor (input valid, ready, status, slot_out, owner_out, last);
endinterface

// ===== design/multi_channel_software_timer_table.sv =====
// Software timer table with one-shot and periodic slots on a 64-bit tick counter.
// Channels: req takes one operation word (tick, add, start, stop, set_value,
// check); rsp gives result words, the final word of each operation has last set.
// Only one operation is in flight; req is ready again once its last result
// word has been loaded into the output register, so a word may still wait there.
// Steps: tick, start, stop, set_value and unknown kinds load their result word
// in the execute state after acceptance; add walks free slots from slot 0 up, one
// slot tested per cycle; check decodes, then scans all 16 slots for expiry (one
// 65-bit add and compare per slot), then walks the slots while results are emitted.
// Reset: tick counter to 1, all slots free and stopped, owners to no task,
// output empty. When the receiver stalls, the result word holds and the walk
// pauses at the current slot until the word is taken.
module multi_channel_software_timer_table (
    input  logic clk,
    input  logic rst_n,
    tmr_req_if.sink   req,
    tmr_rsp_if.source rsp
);
    import tmr_pkg::*;

    tmr_cmd_t  cmd;
    tmr_stat_t stat;

    // sequencing
    tmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // timer storage and arithmetic
    tmr_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .kind           (req.kind),
        .slot           (req.slot),
        .period_ms      (req.period_ms),
        .periodic       (req.periodic),
        .requester_task (req.requester_task),
        .status         (rsp.status),
        .slot_out       (rsp.slot_out),
        .owner_out      (rsp.owner_out),
        .last           (rsp.last)
    );

endmodule

// ===== design/tmr_ctrl.sv =====
// controller state machine sequencing operations and result handshake
module tmr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  tmr_pkg::tmr_stat_t stat,
    output tmr_pkg::tmr_cmd_t  cmd
);
    import tmr_pkg::*;

    tmr_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // output slot is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign req_ready = (state_reg == S_IDLE);

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.out_status    = ST_DONE;
        cmd.out_last      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                unique case (stat.kind)
                    OP_TICK:
                    begin
                        if (out_free)
                        begin
                            cmd.tick     = 1'b1;
                            cmd.out_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    OP_ADD:
                    begin
                        // walk slots upward until a free one or the end
                        priority if (stat.slot_free)
                        begin
                            if (out_free)
                            begin
                                cmd.add_wr      = 1'b1;
                                cmd.out_load    = 1'b1;
                                cmd.out_use_idx = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else if (stat.idx_last)
                        begin
                            if (out_free)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_FULL;
                                state_next     = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                    OP_START:
                    begin
                        if (out_free)
                        begin
                            cmd.start_wr   = stat.slot_ok;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = stat.slot_ok ? ST_DONE : ST_IGNORED;
                            state_next     = S_IDLE;
                        end
                    end
                    OP_STOP:
                    begin
                        if (out_free)
                        begin
                            cmd.stop_wr    = stat.slot_ok;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = stat.slot_ok ? ST_DONE : ST_IGNORED;
                            state_next     = S_IDLE;
                        end
                    end
                    OP_SETVAL:
                    begin
                        if (out_free)
                        begin
                            cmd.period_wr  = stat.slot_ok && !stat.slot_running;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = (stat.slot_ok && !stat.slot_running) ?
                                             ST_DONE : ST_IGNORED;
                            state_next     = S_IDLE;
                        end
                    end
                    OP_CHECK:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_IGNORED;
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end

            S_SCAN:
            begin
                // one expiry test per cycle into the mask
                cmd.mask_wr = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.idx_zero = 1'b1;
                    state_next   = S_EMIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end

            S_EMIT:
            begin
                priority if (stat.mask_zero)
                begin
                    if (out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_NONE;
                        state_next     = S_IDLE;
                    end
                end
                else if (stat.mask_bit)
                begin
                    if (out_free)
                    begin
                        cmd.expire_wr     = 1'b1;
                        cmd.out_load      = 1'b1;
                        cmd.out_status    = ST_EXPIRED;
                        cmd.out_use_idx   = 1'b1;
                        cmd.out_use_owner = 1'b1;
                        cmd.out_last      = stat.mask_last;
                        if (stat.mask_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid follows loads and drains
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

// ===== design/tmr_dp.sv =====
// datapath: tick counter, slot table, expiry test and result register
module tmr_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  tmr_pkg::tmr_cmd_t  cmd,
    output tmr_pkg::tmr_stat_t stat,
    input  logic [2:0]         kind,
    input  logic [3:0]         slot,
    input  logic [31:0]        period_ms,
    input  logic               periodic,
    input  logic [4:0]         requester_task,
    output logic [2:0]         status,
    output logic [3:0]         slot_out,
    output logic [4:0]         owner_out,
    output logic               last
);
    import tmr_pkg::*;

    // latched request word
    logic [2:0]          kind_reg;
    logic [PERIOD_W-1:0] period_in_reg;
    logic                periodic_reg;
    logic [OWNER_W-1:0]  task_reg;
    logic                slot_range_reg;

    // walk index and expiry mask
    logic [SLOT_W-1:0]      idx_reg;
    logic [TIMER_SLOTS-1:0] mask_reg;

    // timer state
    logic [TICK_W-1:0]      tick_reg;
    logic [TICK_W-1:0]      stamp_reg [TIMER_SLOTS];
    logic [PERIOD_W-1:0]    period_reg [TIMER_SLOTS];
    logic [OWNER_W-1:0]     owner_reg [TIMER_SLOTS];
    logic                   repeat_reg [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] in_use_reg;

    // result word
    logic [2:0]         status_reg;
    logic [3:0]         slot_out_reg;
    logic [OWNER_W-1:0] owner_out_reg;
    logic               last_reg;

    logic [TICK_W:0]        due;
    logic                   expired;
    logic                   running;
    logic [TIMER_SLOTS-1:0] cur_bit;

    // expiry test of the slot under the index, exact over 65 bits
    assign running = (stamp_reg[idx_reg] != '0);
    assign due     = {1'b0, stamp_reg[idx_reg]} + {{(TICK_W-PERIOD_W+1){1'b0}},
                                                   period_reg[idx_reg]};
    assign expired = !due[TICK_W] && (tick_reg >= due[TICK_W-1:0]);
    assign cur_bit = TIMER_SLOTS'(1) << idx_reg;

    // status toward the controller
    always_comb
    begin
        stat.kind         = kind_reg;
        stat.idx_last     = (idx_reg == LAST_IDX);
        stat.slot_free    = !in_use_reg[idx_reg];
        stat.slot_ok      = slot_range_reg && in_use_reg[idx_reg];
        stat.slot_running = running;
        stat.mask_zero    = (mask_reg == '0);
        stat.mask_bit     = mask_reg[idx_reg];
        stat.mask_last    = ((mask_reg & ~cur_bit) == '0);
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg       <= kind;
            period_in_reg  <= period_ms;
            periodic_reg   <= periodic;
            task_reg       <= requester_task;
            slot_range_reg <= (int'(slot) < TIMER_SLOTS);
        end
    end

    // walk index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.latch)
        begin
            if (kind == OP_ADD || kind == OP_CHECK)
            begin
                idx_reg <= '0;
            end
            else
            begin
                idx_reg <= SLOT_W'(slot);
            end
        end
        else if (cmd.idx_zero)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + SLOT_W'(1);
        end
    end

    // expiry mask built by the scan and drained by the emit walk
    always_ff @(posedge clk)
    begin
        if (cmd.mask_wr)
        begin
            mask_reg[idx_reg] <= in_use_reg[idx_reg] && running && expired;
        end
        else if (cmd.expire_wr)
        begin
            mask_reg[idx_reg] <= 1'b0;
        end
    end

    // tick counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= TICK_W'(1);
        end
        else if (cmd.tick)
        begin
            tick_reg <= tick_reg + TICK_W'(1);
        end
    end

    // slot table with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                stamp_reg[i]  <= '0;
                period_reg[i] <= '0;
                owner_reg[i]  <= OWNER_NONE;
            end
        end
        else
        begin
            if (cmd.add_wr)
            begin
                in_use_reg[idx_reg] <= 1'b1;
                owner_reg[idx_reg]  <= task_reg;
                period_reg[idx_reg] <= period_in_reg;
            end
            if (cmd.period_wr)
            begin
                period_reg[idx_reg] <= period_in_reg;
            end
            if (cmd.start_wr)
            begin
                stamp_reg[idx_reg] <= tick_reg;
            end
            if (cmd.stop_wr)
            begin
                stamp_reg[idx_reg] <= '0;
            end
            if (cmd.expire_wr)
            begin
                stamp_reg[idx_reg] <= repeat_reg[idx_reg] ? tick_reg : '0;
            end
        end
    end

    // repeat mode, written by add only
    always_ff @(posedge clk)
    begin
        if (cmd.add_wr)
        begin
            repeat_reg[idx_reg] <= periodic_reg;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg    <= cmd.out_status;
            slot_out_reg  <= cmd.out_use_idx ? 4'(idx_reg) : 4'd0;
            owner_out_reg <= cmd.out_use_owner ? owner_reg[idx_reg] : OWNER_NONE;
            last_reg      <= cmd.out_last;
        end
    end

    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign owner_out = owner_out_reg;
    assign last      = last_reg;

endmodule

// ===== design/tmr_checker.sv =====
// port-level checks of the timer table, bound to the top level
module tmr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] rsp_status,
    input logic [3:0] rsp_slot_out,
    input logic [4:0] rsp_owner_out,
    input logic       rsp_last
);
    import tmr_pkg::*;

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_slot_out) && $stable(rsp_owner_out) && $stable(rsp_last))
        else $error("result word changed while stalled");

    // one operation at a time: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an operation is in flight");

    // only expiry words can be followed by more words
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_EXPIRED |-> rsp_last)
        else $error("non-expiry result without last");

    // owner is only reported on expiry
    a_owner_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_EXPIRED |-> rsp_owner_out == OWNER_NONE)
        else $error("owner reported on a non-expiry result");

endmodule

bind multi_channel_software_timer_table tmr_checker u_tmr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_slot_out  (rsp.slot_out),
    .rsp_owner_out (rsp.owner_out),
    .rsp_last      (rsp.last)
);

// ===== test/testbench.sv =====
// self-checking testbench for the software timer table: queue-fed driver, predictor, monitor
`timescale 1ns / 100ps

module testbench;
    import tmr_pkg::*;

    // kinds outside the operation set
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    // traffic phases
    localparam int PH_SLOW_RECV = 0;
    localparam int PH_SLOW_SEND = 1;
    localparam int PH_FULL_RATE = 2;

    localparam int RANDOM_OPS = 230;

    typedef struct {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] period_ms;
        logic        periodic;
        logic [4:0]  task_id;
        bit          drain_first;
        int          phase;
    } timer_op_t;

    typedef struct {
        status_t     status;
        logic [3:0]  slot_out;
        logic [4:0]  owner_out;
        logic        last;
    } timer_word_t;

    logic clk;
    logic rst_n;

    tmr_req_if req_ch ();
    tmr_rsp_if rsp_ch ();

    multi_channel_software_timer_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    timer_op_t   op_backlog[$];
    timer_word_t pending_results[$];
    int          fail_count;
    int          traffic_phase;
    int          gen_phase;

    // shadow copy of the timer table
    logic [TICK_W-1:0]   shadow_ticks;
    logic [TICK_W-1:0]   shadow_stamp  [TIMER_SLOTS];
    logic [PERIOD_W-1:0] shadow_period [TIMER_SLOTS];
    logic                shadow_repeat [TIMER_SLOTS];
    logic [OWNER_W-1:0]  shadow_owner  [TIMER_SLOTS];
    logic                shadow_used   [TIMER_SLOTS];

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int send_idle_pct(input int ph);
        return (ph == PH_SLOW_RECV) ? 10 : (ph == PH_SLOW_SEND) ? 58 : 0;
    endfunction

    function automatic int recv_idle_pct(input int ph);
        return (ph == PH_SLOW_RECV) ? 58 : (ph == PH_SLOW_SEND) ? 10 : 0;
    endfunction

    function automatic void push_word(input status_t st, input logic [3:0] sl,
                                      input logic [4:0] own, input logic lst);
        timer_word_t w;
        w.status    = st;
        w.slot_out  = sl;
        w.owner_out = own;
        w.last      = lst;
        pending_results.push_back(w);
    endfunction

    // predicts the result words of one operation and updates the shadow table
    task automatic advance_timer_table(input logic [2:0] kind, input logic [3:0] slot,
                                       input logic [31:0] pms, input logic per,
                                       input logic [4:0] tid);
        logic        usable;
        logic        claimed;
        logic [64:0] due;
        int          hits;
        usable  = shadow_used[slot];
        claimed = 1'b0;
        hits    = 0;
        case (kind)
            OP_TICK:
            begin
                shadow_ticks = shadow_ticks + 64'd1;
                push_word(ST_DONE, 4'd0, OWNER_NONE, 1'b1);
            end
            OP_ADD:
            begin
                for (int i = 0; i < TIMER_SLOTS; i++)
                begin
                    if (!claimed && !shadow_used[i])
                    begin
                        shadow_owner[i]  = tid;
                        shadow_repeat[i] = per;
                        shadow_period[i] = pms;
                        shadow_used[i]   = 1'b1;
                        claimed          = 1'b1;
                        push_word(ST_DONE, 4'(i), OWNER_NONE, 1'b1);
                    end
                end
                if (!claimed)
                    push_word(ST_FULL, 4'd0, OWNER_NONE, 1'b1);
            end
            OP_START:
            begin
                if (usable)
                begin
                    shadow_stamp[slot] = shadow_ticks;
                    push_word(ST_DONE, 4'd0, OWNER_NONE, 1'b1);
                end
                else
                    push_word(ST_IGNORED, 4'd0, OWNER_NONE, 1'b1);
            end
            OP_STOP:
            begin
                if (usable)
                begin
                    shadow_stamp[slot] = '0;
                    push_word(ST_DONE, 4'd0, OWNER_NONE, 1'b1);
                end
                else
                    push_word(ST_IGNORED, 4'd0, OWNER_NONE, 1'b1);
            end
            OP_SETVAL:
            begin
                if (usable && shadow_stamp[slot] == '0)
                begin
                    shadow_period[slot] = pms;
                    push_word(ST_DONE, 4'd0, OWNER_NONE, 1'b1);
                end
                else
                    push_word(ST_IGNORED, 4'd0, OWNER_NONE, 1'b1);
            end
            OP_CHECK:
            begin
                for (int i = 0; i < TIMER_SLOTS; i++)
                begin
                    // exact deadline, a carry out means it never comes
                    due = {1'b0, shadow_stamp[i]} + {33'd0, shadow_period[i]};
                    if (shadow_used[i] && shadow_stamp[i] != '0 && !due[64]
                        && {1'b0, shadow_ticks} >= due)
                    begin
                        push_word(ST_EXPIRED, 4'(i), shadow_owner[i], 1'b0);
                        hits++;
                        shadow_stamp[i] = shadow_repeat[i] ? shadow_ticks : '0;
                    end
                end
                if (hits == 0)
                    push_word(ST_NONE, 4'd0, OWNER_NONE, 1'b1);
                else
                    pending_results[$].last = 1'b1;
            end
            default:
                push_word(ST_IGNORED, 4'd0, OWNER_NONE, 1'b1);
        endcase
    endtask

    function automatic void queue_op(input logic [2:0] kind, input logic [3:0] slot,
                                     input logic [31:0] pms, input logic per,
                                     input logic [4:0] tid, input bit drain);
        timer_op_t op;
        op.kind        = kind;
        op.slot        = slot;
        op.period_ms   = pms;
        op.periodic    = per;
        op.task_id     = tid;
        op.drain_first = drain;
        op.phase       = gen_phase;
        op_backlog.push_back(op);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        timer_op_t nxt;
        if (!rst_n)
        begin
            req_ch.valid          <= 1'b0;
            req_ch.kind           <= OP_TICK;
            req_ch.slot           <= '0;
            req_ch.period_ms      <= '0;
            req_ch.periodic       <= 1'b0;
            req_ch.requester_task <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                advance_timer_table(req_ch.kind, req_ch.slot, req_ch.period_ms,
                                    req_ch.periodic, req_ch.requester_task);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (op_backlog.size() > 0
                    && $urandom_range(0, 99) >= send_idle_pct(op_backlog[0].phase)
                    && (!op_backlog[0].drain_first
                        || (pending_results.size() == 0 && !rsp_ch.valid
                            && !req_ch.valid)))
                begin
                    nxt = op_backlog.pop_front();
                    req_ch.valid          <= 1'b1;
                    req_ch.kind           <= nxt.kind;
                    req_ch.slot           <= nxt.slot;
                    req_ch.period_ms      <= nxt.period_ms;
                    req_ch.periodic       <= nxt.periodic;
                    req_ch.requester_task <= nxt.task_id;
                    traffic_phase         <= nxt.phase;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        timer_word_t exp_w;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result word: status %0d slot_out %0d owner_out %0d",
                           rsp_ch.status, rsp_ch.slot_out, rsp_ch.owner_out);
                    fail_count++;
                end
                else
                begin
                    exp_w = pending_results.pop_front();
                    if (rsp_ch.status !== exp_w.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_w.status,
                               rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.slot_out !== exp_w.slot_out)
                    begin
                        $error("slot_out: expected %0d, actual %0d", exp_w.slot_out,
                               rsp_ch.slot_out);
                        fail_count++;
                    end
                    if (rsp_ch.owner_out !== exp_w.owner_out)
                    begin
                        $error("owner_out: expected %0d, actual %0d", exp_w.owner_out,
                               rsp_ch.owner_out);
                        fail_count++;
                    end
                    if (rsp_ch.last !== exp_w.last)
                    begin
                        $error("last: expected %0d, actual %0d", exp_w.last, rsp_ch.last);
                        fail_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct(traffic_phase));
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("** multi_channel_software_timer_table: FAILED **");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int          added;
        int          roll;
        logic [3:0]  sl;
        logic [31:0] pms;
        logic [2:0]  kind;

        fail_count    = 0;
        traffic_phase = PH_SLOW_RECV;
        gen_phase     = PH_SLOW_RECV;
        added         = 3;
        rst_n         = 1'b0;

        // shadow table after reset
        shadow_ticks = 64'd1;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            shadow_stamp[i]  = '0;
            shadow_period[i] = '0;
            shadow_repeat[i] = 1'b0;
            shadow_owner[i]  = OWNER_NONE;
            shadow_used[i]   = 1'b0;
        end

        // directed: empty table, unusable slots, spare kinds
        queue_op(OP_CHECK, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_START, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_STOP, 4'd15, 32'hFFFF_FFFF, 1'b1, 5'd31, 1'b0);
        queue_op(OP_SETVAL, 4'd3, 32'd5, 1'b0, 5'd0, 1'b0);
        queue_op(KIND_SPARE_A, 4'd15, 32'hFFFF_FFFF, 1'b1, 5'd31, 1'b0);
        queue_op(KIND_SPARE_B, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0);
        // directed: add extremes of period and owner
        queue_op(OP_ADD, 4'd9, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_ADD, 4'd0, 32'd2, 1'b1, 5'd31, 1'b0);
        queue_op(OP_ADD, 4'd0, 32'hFFFF_FFFF, 1'b1, 5'd16, 1'b0);
        // directed: stop while stopped, set_value stopped and running
        queue_op(OP_STOP, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_SETVAL, 4'd0, 32'd1, 1'b0, 5'd0, 1'b0);
        queue_op(OP_START, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_START, 4'd1, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_START, 4'd2, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_SETVAL, 4'd1, 32'd7, 1'b0, 5'd0, 1'b0);
        // directed: expiry of one-shot and periodic, then restart
        queue_op(OP_CHECK, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_TICK, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_TICK, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_CHECK, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_CHECK, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0);
        queue_op(OP_STOP, 4'd1, 32'd0, 1'b0, 5'd0, 1'b1);

        // random: mostly operations on claimed slots with small periods
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            gen_phase = (n < RANDOM_OPS / 3) ? PH_SLOW_RECV :
                        (n < 2 * RANDOM_OPS / 3) ? PH_SLOW_SEND : PH_FULL_RATE;
            roll = $urandom_range(0, 99);
            sl   = (added > 0 && $urandom_range(0, 99) < 80) ?
                   4'($urandom_range(0, (added > 16 ? 16 : added) - 1)) :
                   4'($urandom_range(0, 15));
            pms  = ($urandom_range(0, 99) < 85) ? 32'($urandom_range(0, 6)) : $urandom();
            if (roll < 30)
                kind = OP_TICK;
            else if (roll < 45)
                kind = OP_CHECK;
            else if (roll < 60)
                kind = OP_START;
            else if (roll < 68)
                kind = OP_STOP;
            else if (roll < 76)
                kind = OP_SETVAL;
            else if (roll < 86)
                kind = OP_ADD;
            else if (roll < 89)
                kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
            else
            begin
                // noise word
                kind = 3'($urandom_range(0, 7));
                sl   = 4'($urandom_range(0, 15));
                pms  = $urandom();
            end
            if (kind == OP_ADD)
                added++;
            queue_op(kind, sl, pms, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                     (n % 40) == 39);
        end

        // release reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // drain
        while (op_backlog.size() > 0 || req_ch.valid)
            @(posedge clk);
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (fail_count == 0)
            $display("** multi_channel_software_timer_table: PASSED **");
        else
            $display("** multi_channel_software_timer_table: FAILED **");
        $finish;
    end

endmodule
